// File: rtl/pmid_pkg.sv
// Shared widths and types for the periodic minimum image distance block.
`default_nettype none
package pmid_pkg;
	localparam int COORD_BITS = 32;
	localparam int CELL_BITS  = 31;
	localparam int MAG_BITS   = COORD_BITS + 1;
	localparam int HALF_BITS  = CELL_BITS - 1;
	localparam int SQ_BITS    = 2 * HALF_BITS;
	localparam int SUM_BITS   = SQ_BITS + 2;
	localparam int ROOT_BITS  = SUM_BITS / 2;
	localparam int AXES       = 3;
	localparam int LANE_LAT   = MAG_BITS + 3;
	localparam int ADDR_BITS  = 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [CELL_BITS-1:0]         cell_t;
	typedef logic [SQ_BITS-1:0]           sq_t;
	typedef logic [SUM_BITS-1:0]          sum_t;
	typedef logic [ROOT_BITS-1:0]         root_t;

	typedef enum logic [1:0] {
		REG_CELL_X = 2'd0,
		REG_CELL_Y = 2'd1,
		REG_CELL_Z = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;
endpackage
`default_nettype wire

// File: rtl/pmid_lane.sv
// One axis lane: difference, pipelined modulo by the edge, fold and square.
`default_nettype none
module pmid_lane (
	input  wire               clk,
	input  pmid_pkg::coord_t  a,
	input  pmid_pkg::coord_t  b,
	input  pmid_pkg::cell_t   span,
	output pmid_pkg::sq_t     sq
);
	import pmid_pkg::*;

	logic signed [MAG_BITS-1:0] e;
	logic [MAG_BITS-1:0]  mag_s [0:MAG_BITS];
	logic                 neg_s [0:MAG_BITS];
	logic [CELL_BITS-1:0] rem_s [1:MAG_BITS];
	logic [CELL_BITS-1:0] r_fix;
	logic [CELL_BITS-1:0] r_fold;
	logic [HALF_BITS-1:0] fold_s;
	sq_t                  sq_s;

	// negated difference at full width, split into sign and magnitude
	assign e = MAG_BITS'($signed(b)) - MAG_BITS'($signed(a));
	always_ff @(posedge clk) begin
		neg_s[0] <= e[MAG_BITS-1];
		mag_s[0] <= e[MAG_BITS-1] ? MAG_BITS'(-e) : MAG_BITS'(e);
	end

	// restoring remainder, one magnitude bit per stage
	for (genvar k = 0; k < MAG_BITS; k++) begin : g_div
		logic [CELL_BITS:0] t;
		if (k == 0) begin : g_first
			assign t = {{CELL_BITS{1'b0}}, mag_s[k][MAG_BITS-1]};
		end else begin : g_rest
			assign t = {rem_s[k], mag_s[k][MAG_BITS-1]};
		end
		always_ff @(posedge clk) begin
			neg_s[k+1] <= neg_s[k];
			mag_s[k+1] <= {mag_s[k][MAG_BITS-2:0], 1'b0};
			if (t >= {1'b0, span}) begin
				rem_s[k+1] <= CELL_BITS'(t - {1'b0, span});
			end else begin
				rem_s[k+1] <= t[CELL_BITS-1:0];
			end
		end
	end

	// map into [0, edge), then fold onto [0, edge/2]
	always_comb begin
		if (neg_s[MAG_BITS] && (rem_s[MAG_BITS] != '0)) begin
			r_fix = span - rem_s[MAG_BITS];
		end else begin
			r_fix = rem_s[MAG_BITS];
		end
		if (span == '0) begin
			r_fold = '0;
		end else if ({r_fix, 1'b0} > {1'b0, span}) begin
			r_fold = span - r_fix;
		end else begin
			r_fold = r_fix;
		end
	end

	always_ff @(posedge clk) begin
		fold_s <= r_fold[HALF_BITS-1:0];
		sq_s   <= SQ_BITS'(fold_s) * SQ_BITS'(fold_s);
	end

	assign sq = sq_s;
endmodule
`default_nettype wire

// File: rtl/pmid_sqrt.sv
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module pmid_sqrt (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	input  pmid_pkg::sum_t  n,
	output wire             out_valid,
	output pmid_pkg::root_t root
);
	import pmid_pkg::*;

	localparam int REM_W = ROOT_BITS + 2;

	logic [SUM_BITS-1:0]  n_s    [0:ROOT_BITS];
	logic [REM_W-1:0]     rem_s  [1:ROOT_BITS];
	logic [ROOT_BITS-1:0] root_s [1:ROOT_BITS];
	logic                 vld_q  [1:ROOT_BITS];

	assign n_s[0] = n;

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
		logic [REM_W+1:0]     cur;
		logic [REM_W+1:0]     trial;
		logic [ROOT_BITS-1:0] rt;
		logic                 vin;
		if (k == 0) begin : g_first
			assign cur = {{REM_W{1'b0}}, n_s[k][SUM_BITS-1:SUM_BITS-2]};
			assign rt  = '0;
			assign vin = in_valid;
		end else begin : g_rest
			assign cur = {rem_s[k], n_s[k][SUM_BITS-1:SUM_BITS-2]};
			assign rt  = root_s[k];
			assign vin = vld_q[k];
		end
		assign trial = (REM_W + 2)'({rt, 2'b01});

		// try the next root bit, keep it where the remainder allows
		always_ff @(posedge clk) begin
			n_s[k+1] <= {n_s[k][SUM_BITS-3:0], 2'b00};
			if (cur >= trial) begin
				rem_s[k+1]  <= REM_W'(cur - trial);
				root_s[k+1] <= {rt[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= cur[REM_W-1:0];
				root_s[k+1] <= {rt[ROOT_BITS-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else begin
				vld_q[k+1] <= vin;
			end
		end
	end

	assign out_valid = vld_q[ROOT_BITS];
	assign root      = root_s[ROOT_BITS];
endmodule
`default_nettype wire

// File: rtl/periodic_min_image_distance_3d.sv
// Top level: config registers, three axis lanes, sum of squares and root.
//
//  channel | signals                              | beat taken when
//  --------+--------------------------------------+---------------------------
//  input   | start, busy, a_x..a_z, b_x..b_z      | start high, busy low
//  result  | done, distance                       | done high (one cycle)
//  config  | psel penable pwrite paddr pwdata     | psel, penable, pwrite high
//          | prdata pready                        |
//
// One item per cycle; busy stays low. The path runs through the 33-stage
// modulo pipeline in each lane and the 31-stage square root. Reset sets all
// edges to 1.0 and empties the pipeline. The result side cannot stall, so
// nothing here ever holds a beat back.
`default_nettype none
module periodic_min_image_distance_3d (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output wire                                 busy,
	input  pmid_pkg::coord_t                    a_x,
	input  pmid_pkg::coord_t                    a_y,
	input  pmid_pkg::coord_t                    a_z,
	input  pmid_pkg::coord_t                    b_x,
	input  pmid_pkg::coord_t                    b_y,
	input  pmid_pkg::coord_t                    b_z,
	output wire                                 done,
	output pmid_pkg::root_t                     distance,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire [pmid_pkg::ADDR_BITS-1:0]       paddr,
	input  wire [31:0]                          pwdata,
	output logic [31:0]                         prdata,
	output wire                                 pready
);
	import pmid_pkg::*;

	cell_t    cell_x_q, cell_y_q, cell_z_q;
	reg_idx_t idx;
	logic     wr;
	coord_t   a_v [0:AXES-1];
	coord_t   b_v [0:AXES-1];
	cell_t    c_v [0:AXES-1];
	sq_t      sq_v [0:AXES-1];
	logic [LANE_LAT-1:0] vld_q;
	logic     sum_vld_s;
	sum_t     sum_s;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;

	// write edge registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_x_q <= CELL_BITS'(65536);
			cell_y_q <= CELL_BITS'(65536);
			cell_z_q <= CELL_BITS'(65536);
		end else if (wr) begin
			case (idx)
				REG_CELL_X: cell_x_q <= pwdata[CELL_BITS-1:0];
				REG_CELL_Y: cell_y_q <= pwdata[CELL_BITS-1:0];
				REG_CELL_Z: cell_z_q <= pwdata[CELL_BITS-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_CELL_X: prdata = 32'(cell_x_q);
			REG_CELL_Y: prdata = 32'(cell_y_q);
			REG_CELL_Z: prdata = 32'(cell_z_q);
			default:    prdata = '0;
		endcase
	end

	assign a_v[0] = a_x;
	assign a_v[1] = a_y;
	assign a_v[2] = a_z;
	assign b_v[0] = b_x;
	assign b_v[1] = b_y;
	assign b_v[2] = b_z;
	assign c_v[0] = cell_x_q;
	assign c_v[1] = cell_y_q;
	assign c_v[2] = cell_z_q;

	for (genvar i = 0; i < AXES; i++) begin : g_lane
		pmid_lane u_lane (
			.clk  (clk),
			.a    (a_v[i]),
			.b    (b_v[i]),
			.span (c_v[i]),
			.sq   (sq_v[i])
		);
	end

	// advance the valid mark alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			sum_vld_s <= 1'b0;
		end else begin
			vld_q     <= {vld_q[LANE_LAT-2:0], start};
			sum_vld_s <= vld_q[LANE_LAT-1];
		end
	end

	// merge the lanes
	always_ff @(posedge clk) begin
		sum_s <= SUM_BITS'(sq_v[0]) + SUM_BITS'(sq_v[1]) + SUM_BITS'(sq_v[2]);
	end

	pmid_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_vld_s),
		.n         (sum_s),
		.out_valid (done),
		.root      (distance)
	);
endmodule
`default_nettype wire
